[src/pc1_pkg.sv]
// Shared types and constants for the PC1 byte stream cipher.
package pc1_pkg;

  // Multiplier constants of the key schedule.
  localparam logic [15:0] MUL_A = 16'h015a;
  localparam logic [15:0] MUL_B = 16'h4e35;

  // Key register reset values: "cy" and "tkeyadi2".
  localparam logic [15:0] KEY_UPPER_RESET = 16'h6379;
  localparam logic [63:0] KEY_LOWER_RESET = 64'h746b657961646932;

  localparam int KEY_BYTES  = 10;
  localparam int KEY_W      = 8 * KEY_BYTES;
  localparam int NUM_ROUNDS = 5;
  localparam int ROUND_W    = $clog2(NUM_ROUNDS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_UPPER = 1'b0,
    CFG_KEY_LOWER = 1'b1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_X1A2_B,
    MUL_W_A,
    MUL_W_B
  } mul_sel_e;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic               in_ready;
    logic               mul_en;
    mul_sel_e           mul_sel;
    logic [ROUND_W-1:0] round;
    logic               take_t;
    logic               take_d;
    logic               take_a;
    logic               finish;
  } ctrl_t;

endpackage

[src/pc1_in_if.sv]
// Input byte channel of the PC1 cipher.
interface pc1_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       first_byte;
  logic [7:0] data_in;

  modport source (output valid, output cmd, output first_byte, output data_in, input ready);
  modport sink   (input valid, input cmd, input first_byte, input data_in, output ready);
endinterface

[src/pc1_out_if.sv]
// Output byte channel of the PC1 cipher.
interface pc1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

[src/pc1_mul.sv]
// Shared 16x16 multiplier with a registered low-half product.
module pc1_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] op_a_i,
  input  logic [15:0] op_b_i,
  output logic [15:0] prod_o
);
  import pc1_pkg::*;

  logic [31:0] full;
  logic [15:0] prod_d, prod_q;

  // Only the low 16 bits matter since the schedule wraps at 16 bits.
  assign full   = op_a_i * op_b_i;
  assign prod_d = full[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule

[src/pc1_seq.sv]
// Sequencer stepping the five key rounds through the shared multiplier.
module pc1_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          out_free_i,
  output pc1_pkg::ctrl_t ctrl_o
);
  import pc1_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

  state_e             state_q, state_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [1:0]         phase_q, phase_d;

  // State, round and phase registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      phase_q <= phase_d;
    end
  end

  // Each round issues three products: (x1a2 + r) * B, w * A, w * B.
  // Each product is consumed in the cycle after it is issued, except the last w * B product, which waits for finish.
  always_comb begin
    state_d        = state_q;
    round_d        = round_q;
    phase_d        = phase_q;
    ctrl_o         = '0;
    ctrl_o.round   = round_q;
    ctrl_o.mul_sel = MUL_X1A2_B;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (start_i) begin
          state_d = ST_RUN;
          round_d = '0;
          phase_d = 2'd0;
        end
      end
      ST_RUN: begin
        ctrl_o.mul_en = 1'b1;
        case (phase_q)
          2'd0: begin
            ctrl_o.mul_sel = MUL_X1A2_B;
            ctrl_o.take_a  = (round_q != '0);
            phase_d        = 2'd1;
          end
          2'd1: begin
            ctrl_o.mul_sel = MUL_W_A;
            ctrl_o.take_t  = 1'b1;
            phase_d        = 2'd2;
          end
          2'd2: begin
            ctrl_o.mul_sel = MUL_W_B;
            ctrl_o.take_d  = 1'b1;
            phase_d        = 2'd0;
            if (round_q == LAST_ROUND) begin
              state_d = ST_FINISH;
            end else begin
              round_d = round_q + 1'b1;
            end
          end
          default: begin
            phase_d = 2'd0;
          end
        endcase
      end
      ST_FINISH: begin
        // The last w * B product waits here until the output register is free.
        if (out_free_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

[src/pc1_byte_stream_cipher_top.sv]
// Top level of the PC1 byte stream cipher: key state, datapath and channels.
//
// Each byte beat goes through an accept step, then five rounds of three 16-bit
// products, all issued on the one shared multiplier, then a finishing step that
// forms the pad and updates the running key, held until the output register is
// free. The result sits in an output register, so a new byte beat can be
// accepted while the previous result is still waiting to be taken. Key writes on
// the configuration port take effect at the next byte beat that has first_byte
// set; write only while the block is idle.
module pc1_byte_stream_cipher_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pc1_in_if.sink                         in_ch,
  pc1_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [pc1_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pc1_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pc1_pkg::*;

  ctrl_t       ctrl;
  logic        start;
  logic        out_free;

  logic [15:0] key_upper_q;
  logic [63:0] key_lower_q;
  logic [KEY_W-1:0] key_q, key_d;
  logic [15:0] si_q, x1a2_q;
  logic [15:0] t_q, d_q, prev_q, interval_q;
  logic        cmd_q;
  logic [7:0]  din_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;

  logic [15:0] kw, w, x1a2_r, op_a, op_b, prod, a_word, d_word, interval_fin;
  logic [7:0]  pad, res, plain;

  assign start    = in_ch.valid & ctrl.in_ready;
  assign out_free = ~out_valid_q | out_ch.ready;

  pc1_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Key word of the current round, byte 2r high and byte 2r+1 low.
  always_comb begin
    kw = 16'h0000;
    case (ctrl.round)
      3'd0:    kw = key_q[79:64];
      3'd1:    kw = key_q[63:48];
      3'd2:    kw = key_q[47:32];
      3'd3:    kw = key_q[31:16];
      3'd4:    kw = key_q[15:0];
      default: kw = 16'h0000;
    endcase
  end

  // Round word: the first round uses the key word alone.
  assign w      = (ctrl.round == '0) ? kw : (prev_q ^ kw);
  assign x1a2_r = 16'(x1a2_q + {{(16 - ROUND_W){1'b0}}, ctrl.round});

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = x1a2_r;
    op_b = MUL_B;
    case (ctrl.mul_sel)
      MUL_X1A2_B: begin
        op_a = x1a2_r;
        op_b = MUL_B;
      end
      MUL_W_A: begin
        op_a = w;
        op_b = MUL_A;
      end
      MUL_W_B: begin
        op_a = w;
        op_b = MUL_B;
      end
      default: begin
        op_a = x1a2_r;
        op_b = MUL_B;
      end
    endcase
  end

  pc1_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Round combination from the registered products.
  assign d_word       = 16'(prod + t_q + si_q);
  assign a_word       = 16'(prod + 16'd1);
  assign interval_fin = interval_q ^ a_word ^ d_q;
  assign pad          = interval_fin[15:8] ^ interval_fin[7:0];
  assign res          = din_q ^ pad;
  assign plain        = cmd_q ? res : din_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= KEY_UPPER_RESET;
      key_lower_q <= KEY_LOWER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_UPPER: key_upper_q <= cfg_data_i[15:0];
        CFG_KEY_LOWER: key_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running key: reloaded on a first byte, mixed with the plaintext at finish.
  always_comb begin
    key_d = key_q;
    if (start && in_ch.first_byte) begin
      key_d = {key_upper_q, key_lower_q};
    end else if (ctrl.finish) begin
      key_d = key_q ^ {KEY_BYTES{plain}};
    end
  end

  // Persistent mixing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= {KEY_UPPER_RESET, KEY_LOWER_RESET};
      si_q   <= '0;
      x1a2_q <= '0;
    end else begin
      key_q <= key_d;
      if (start && in_ch.first_byte) begin
        si_q   <= '0;
        x1a2_q <= '0;
      end else if (ctrl.take_d) begin
        si_q   <= prod;
        x1a2_q <= d_word;
      end
    end
  end

  // Per-byte working registers.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q      <= in_ch.cmd;
      din_q      <= in_ch.data_in;
      interval_q <= '0;
    end
    if (ctrl.take_t) begin
      t_q <= prod;
    end
    if (ctrl.take_d) begin
      d_q <= d_word;
    end
    if (ctrl.take_a) begin
      prev_q     <= a_word;
      interval_q <= interval_fin;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_data_q <= res;
    end
  end

  assign in_ch.ready     = ctrl.in_ready;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.data_out = out_data_q;

`ifndef NO_ASSERTIONS
  // A byte is never accepted in two consecutive cycles.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a byte was in progress");

  // A new result appears only from the finishing step.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(ctrl.finish))
    else $error("output valid rose without a finished byte");

  // The round counter stays within the schedule.
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.round < ROUND_W'(NUM_ROUNDS))
    else $error("round counter out of range");

  // Finishing never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> (!out_valid_q || out_ch.ready))
    else $error("pending result overwritten");
`endif
endmodule
